// ----- rtl/sra_pkg.sv -----
// ----------------------------------------------------------------------------
// sra_pkg
// Shared constants, codes and helpers for the selective-repeat ARQ window.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int unsigned MAX_WINDOW = 16;
  localparam int unsigned SEQ_WIDTH  = 5;
  localparam int unsigned SLOT_W     = $clog2(MAX_WINDOW);
  localparam int unsigned BITS_W     = 3;

  localparam logic [BITS_W-1:0] SEQ_BITS_RST = 3'd3;
  localparam logic [BITS_W-1:0] SEQ_BITS_MAX = 3'd5;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_START  = 1'b1;

  localparam logic RK_REPORT = 1'b0;
  localparam logic RK_FRAME  = 1'b1;

  localparam logic [1:0] OC_ACKED   = 2'd0;
  localparam logic [1:0] OC_ACKLOST = 2'd1;
  localparam logic [1:0] OC_DAMAGED = 2'd2;
  localparam logic [1:0] OC_LOST    = 2'd3;

  localparam logic [2:0] ST_SKIPPED = 3'd0;
  localparam logic [2:0] ST_ACKED   = 3'd1;
  localparam logic [2:0] ST_ACKLOST = 3'd2;
  localparam logic [2:0] ST_DAMAGED = 3'd3;
  localparam logic [2:0] ST_LOST    = 3'd4;

  // clamp requested sequence width to 1..SEQ_WIDTH
  function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] b);
    logic [BITS_W-1:0] r;
    r = b;
    if (b == '0) r = 3'd1;
    else if (b > SEQ_BITS_MAX) r = SEQ_BITS_MAX;
    return r;
  endfunction

  // window size minus one: 2^(b-1) - 1
  function automatic logic [SLOT_W-1:0] win_last(input logic [BITS_W-1:0] b);
    logic [SEQ_WIDTH-1:0] w;
    w = SEQ_WIDTH'(1) << (b - 3'd1);
    return SLOT_W'(w - SEQ_WIDTH'(1));
  endfunction

  // modulus minus one: 2^b - 1
  function automatic logic [SEQ_WIDTH-1:0] seq_mask(input logic [BITS_W-1:0] b);
    logic [SEQ_WIDTH:0] m;
    m = (SEQ_WIDTH+1)'(1) << b;
    return SEQ_WIDTH'(m - (SEQ_WIDTH+1)'(1));
  endfunction

endpackage

// ----- rtl/sra_if.sv -----
// ----------------------------------------------------------------------------
// sra_in_if / sra_out_if
// Valid/ready channels for input items and result beats.
// ----------------------------------------------------------------------------
interface sra_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] slot;
  logic [1:0] outcome;
  logic       round_end;

  modport source (output valid, kind, slot, outcome, round_end, input ready);
  modport sink   (input valid, kind, slot, outcome, round_end, output ready);
endinterface

interface sra_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [4:0] seq_number;
  logic [2:0] status;
  logic       receiver_accepted;
  logic       last;

  modport source (output valid, result_kind, seq_number, status, receiver_accepted, last,
                  input ready);
  modport sink   (input valid, result_kind, seq_number, status, receiver_accepted, last,
                  output ready);
endinterface

// ----- rtl/selective_repeat_arq_window_top.sv -----
// ----------------------------------------------------------------------------
// selective_repeat_arq_window_top
// Selective-repeat sender/receiver window with slide and resend list.
// ----------------------------------------------------------------------------
// Items are handled one at a time; the input is ready only while the block is
// idle, and results leave through a one-beat output register. A sequencer
// walks the window one slot per cycle while the output does not stall. A start
// item loads the window and emits its frames; a report looks up its slot,
// searches the receiver window and emits the report beat, and a report that
// ends a round then scans for leading acks, compacts and refills the window
// and emits the unacked frames.
module selective_repeat_arq_window_top
  import sra_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BITS_W-1:0] cfg_wdata_i,
  sra_in_if.sink            in_i,
  sra_out_if.source         out_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_SRCH   = 3'd2;
  localparam logic [2:0] S_REPORT = 3'd3;
  localparam logic [2:0] S_SKIP   = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [BITS_W-1:0]    seq_bits_q;
  logic [BITS_W-1:0]    act_q;
  logic [SEQ_WIDTH-1:0] send_seq_q [MAX_WINDOW];
  logic [SEQ_WIDTH-1:0] recv_seq_q [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] send_acked_q;
  logic [SEQ_WIDTH-1:0] next_send_q, next_recv_q;
  logic [SLOT_W-1:0]    idx_q, slot_q;
  logic [SLOT_W:0]      j_q;
  logic [1:0]           outcome_q;
  logic                 rend_q;
  logic [SEQ_WIDTH-1:0] seq_q;
  logic [2:0]           st_q;
  logic                 acc_q;

  logic                 out_valid_q;
  logic                 out_kind_q, out_acc_q, out_last_q;
  logic [SEQ_WIDTH-1:0] out_seq_q;
  logic [2:0]           out_st_q;

  logic                 in_fire, out_free, out_push;
  logic                 push_kind, push_acc, push_last;
  logic [SEQ_WIDTH-1:0] push_seq;
  logic [2:0]           push_st;

  logic [SLOT_W-1:0]    wm1, new_wm1, rd_idx;
  logic [SEQ_WIDTH-1:0] mask;
  logic [BITS_W-1:0]    new_act;
  logic [SLOT_W:0]      src;
  logic [SEQ_WIDTH-1:0] rd_seq;
  logic                 rd_acked;
  logic                 in_range, src_in, idx_end, later;
  logic [MAX_WINDOW-1:0] pend;

  assign wm1      = win_last(act_q);
  assign mask     = seq_mask(act_q);
  assign new_act  = clamp_bits(seq_bits_q);
  assign new_wm1  = win_last(new_act);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign src      = (SLOT_W+1)'(idx_q) + j_q;
  assign src_in   = src <= {1'b0, wm1};
  assign in_range = slot_q <= wm1;
  assign idx_end  = idx_q == wm1;

  always_comb begin
    unique case (state_q)
      S_LOOK:  rd_idx = slot_q;
      S_SHIFT: rd_idx = src[SLOT_W-1:0];
      default: rd_idx = idx_q;
    endcase
  end
  assign rd_seq   = send_seq_q[rd_idx];
  assign rd_acked = send_acked_q[rd_idx];

  // unacked slots after the current emit position
  always_comb begin
    for (int b = 0; b < MAX_WINDOW; b++) begin
      pend[b] = !send_acked_q[b] && (SLOT_W'(b) <= wm1) && (SLOT_W'(b) > idx_q);
    end
  end
  assign later = |pend;

  assign in_i.ready = state_q == S_IDLE;

  always_comb begin
    state_d   = state_q;
    out_push  = 1'b0;
    push_kind = RK_FRAME;
    push_seq  = rd_seq;
    push_st   = ST_SKIPPED;
    push_acc  = 1'b0;
    push_last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = (in_i.kind == KIND_START) ? S_EMIT : S_LOOK;
      end
      S_LOOK: begin
        if (in_range && !rd_acked && (outcome_q == OC_ACKED || outcome_q == OC_ACKLOST))
          state_d = S_SRCH;
        else
          state_d = S_REPORT;
      end
      S_SRCH: begin
        if (recv_seq_q[idx_q] == seq_q || idx_end) state_d = S_REPORT;
      end
      S_REPORT: begin
        push_kind = RK_REPORT;
        push_seq  = seq_q;
        push_st   = st_q;
        push_acc  = acc_q;
        push_last = !rend_q;
        if (out_free) begin
          out_push = 1'b1;
          state_d  = rend_q ? S_SKIP : S_IDLE;
        end
      end
      S_SKIP: begin
        if (!(j_q <= {1'b0, wm1} && send_acked_q[j_q[SLOT_W-1:0]])) state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (idx_end) state_d = S_EMIT;
      end
      S_EMIT: begin
        push_last = !later;
        if (rd_acked) begin
          if (idx_end) state_d = S_IDLE;
        end else if (out_free) begin
          out_push = 1'b1;
          if (idx_end) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      seq_bits_q   <= SEQ_BITS_RST;
      act_q        <= clamp_bits(SEQ_BITS_RST);
      send_acked_q <= '0;
      next_send_q  <= '0;
      next_recv_q  <= '0;
      idx_q        <= '0;
      j_q          <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        send_seq_q[i] <= '0;
        recv_seq_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) seq_bits_q <= cfg_wdata_i;
      unique case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (in_fire && in_i.kind == KIND_START) begin
            act_q        <= new_act;
            send_acked_q <= '0;
            next_send_q  <= SEQ_WIDTH'(new_wm1) + SEQ_WIDTH'(1);
            next_recv_q  <= SEQ_WIDTH'(new_wm1) + SEQ_WIDTH'(1);
            for (int i = 0; i < MAX_WINDOW; i++) begin
              send_seq_q[i] <= (SLOT_W'(i) <= new_wm1) ? SEQ_WIDTH'(i) : '0;
              recv_seq_q[i] <= (SLOT_W'(i) <= new_wm1) ? SEQ_WIDTH'(i) : '0;
            end
          end
        end
        S_LOOK: begin
          idx_q <= '0;
          j_q   <= '0;
          if (in_range && !rd_acked && outcome_q == OC_ACKED) send_acked_q[slot_q] <= 1'b1;
        end
        S_SRCH: begin
          if (recv_seq_q[idx_q] == seq_q) begin
            recv_seq_q[idx_q] <= next_recv_q;
            next_recv_q       <= (next_recv_q + SEQ_WIDTH'(1)) & mask;
          end
          idx_q <= idx_q + SLOT_W'(1);
        end
        S_REPORT: begin
          idx_q <= '0;
          j_q   <= '0;
        end
        S_SKIP: begin
          idx_q <= '0;
          if (j_q <= {1'b0, wm1} && send_acked_q[j_q[SLOT_W-1:0]]) j_q <= j_q + 1'b1;
        end
        S_SHIFT: begin
          if (src_in) begin
            send_seq_q[idx_q]   <= rd_seq;
            send_acked_q[idx_q] <= rd_acked;
          end else begin
            send_seq_q[idx_q]   <= next_send_q;
            send_acked_q[idx_q] <= 1'b0;
            next_send_q         <= (next_send_q + SEQ_WIDTH'(1)) & mask;
          end
          idx_q <= idx_end ? '0 : idx_q + SLOT_W'(1);
        end
        S_EMIT: begin
          if (rd_acked || out_free) idx_q <= idx_q + SLOT_W'(1);
        end
        default: idx_q <= '0;
      endcase
    end
  end

  // item fields and report result, held while the item is worked on
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      slot_q    <= in_i.slot;
      outcome_q <= in_i.outcome;
      rend_q    <= in_i.round_end;
      acc_q     <= 1'b0;
    end
    if (state_q == S_LOOK) begin
      seq_q <= in_range ? rd_seq : '0;
      st_q  <= ST_SKIPPED;
      if (in_range && !rd_acked) begin
        case (outcome_q)
          OC_ACKED:   st_q <= ST_ACKED;
          OC_ACKLOST: st_q <= ST_ACKLOST;
          OC_DAMAGED: st_q <= ST_DAMAGED;
          default:    st_q <= ST_LOST;
        endcase
      end
    end
    if (state_q == S_SRCH && recv_seq_q[idx_q] == seq_q) acc_q <= 1'b1;
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_kind_q <= push_kind;
      out_seq_q  <= push_seq;
      out_st_q   <= push_st;
      out_acc_q  <= push_acc;
      out_last_q <= push_last;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.result_kind       = out_kind_q;
  assign out_o.seq_number        = out_seq_q;
  assign out_o.status            = out_st_q;
  assign out_o.receiver_accepted = out_acc_q;
  assign out_o.last              = out_last_q;

`ifndef ASSERT_OFF
  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q >= 3'd1 && act_q <= SEQ_BITS_MAX)
    else $error("active sequence width out of range");

  a_start_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.kind == KIND_START |=>
      next_send_q == SEQ_WIDTH'(wm1) + SEQ_WIDTH'(1) && next_recv_q == next_send_q)
    else $error("start did not load next sequence numbers");

  a_ack_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push && state_q == S_REPORT && st_q == ST_ACKED |-> send_acked_q[slot_q])
    else $error("acked report without slot marked");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && !in_fire |=> state_q == S_IDLE)
    else $error("sequencer left idle without a beat");
`endif

endmodule

// ----- verif/sra_checker.sv -----
// ----------------------------------------------------------------------------
// sra_checker
// Watches the config port and both channels of the selective-repeat window.
// Keeps its own copy of the sender and receiver windows, works out the
// result beats owed for every accepted item, and compares each delivered
// beat with the oldest owed one.
// ----------------------------------------------------------------------------
module sra_checker
  import sra_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BITS_W-1:0] cfg_wdata_i,
  sra_in_if                 in_i,
  sra_out_if                out_i,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       mismatches_o
);

  typedef struct packed {
    logic                 rk;
    logic [SEQ_WIDTH-1:0] seq;
    logic [2:0]           st;
    logic                 acc;
    logic                 last;
  } arq_beat_t;

  logic [BITS_W-1:0]    seq_bits_q;
  logic [BITS_W-1:0]    act_bits;
  logic [SEQ_WIDTH-1:0] tx_seq   [MAX_WINDOW];
  logic                 tx_acked [MAX_WINDOW];
  logic [SEQ_WIDTH-1:0] rx_seq   [MAX_WINDOW];
  int unsigned          next_tx;
  int unsigned          next_rx;
  arq_beat_t            owed_q [$];
  arq_beat_t            got;
  arq_beat_t            want;
  int unsigned          n_checked;
  int unsigned          n_bad;

  function automatic int unsigned win_size();
    int unsigned m;
    m = 1 << act_bits;
    return (m / 2 > MAX_WINDOW) ? MAX_WINDOW : m / 2;
  endfunction

  // one frame beat per unacked slot, last flag on the final one
  task automatic owe_frames();
    int unsigned w;
    int unsigned i;
    int          tail;
    w    = win_size();
    tail = -1;
    for (i = 0; i < w; i++) begin
      if (!tx_acked[i]) tail = i;
    end
    for (i = 0; i < w; i++) begin
      if (!tx_acked[i]) begin
        owed_q.push_back('{RK_FRAME, tx_seq[i], ST_SKIPPED, 1'b0, (int'(i) == tail)});
      end
    end
  endtask

  task automatic slide_window();
    int unsigned w;
    int unsigned m;
    int unsigned lead;
    int unsigned fill;
    int unsigned k;
    w    = win_size();
    m    = 1 << act_bits;
    lead = 0;
    fill = 0;
    while (lead < w && tx_acked[lead]) lead++;
    for (k = lead; k < w; k++) begin
      tx_seq[fill]   = tx_seq[k];
      tx_acked[fill] = tx_acked[k];
      fill++;
    end
    for (k = fill; k < w; k++) begin
      tx_seq[k]   = SEQ_WIDTH'(next_tx);
      next_tx     = (next_tx + 1) % m;
      tx_acked[k] = 1'b0;
    end
  endtask

  task automatic step_arq_window(input logic kind, input logic [3:0] slot,
                                 input logic [1:0] oc, input logic rend);
    int unsigned          w;
    int unsigned          m;
    int unsigned          i;
    logic [SEQ_WIDTH-1:0] seq;
    logic [2:0]           st;
    logic                 hit;
    if (kind == KIND_START) begin
      if (seq_bits_q == '0) act_bits = BITS_W'(1);
      else if (seq_bits_q > SEQ_BITS_MAX) act_bits = SEQ_BITS_MAX;
      else act_bits = seq_bits_q;
      w = win_size();
      for (i = 0; i < MAX_WINDOW; i++) begin
        tx_seq[i]   = (i < w) ? SEQ_WIDTH'(i) : '0;
        rx_seq[i]   = tx_seq[i];
        tx_acked[i] = 1'b0;
      end
      next_tx = w % (1 << act_bits);
      next_rx = next_tx;
      owe_frames();
    end else begin
      w   = win_size();
      m   = 1 << act_bits;
      seq = '0;
      st  = ST_SKIPPED;
      hit = 1'b0;
      if (slot < w) begin
        seq = tx_seq[slot];
        if (!tx_acked[slot]) begin
          if (oc == OC_ACKED || oc == OC_ACKLOST) begin
            for (i = 0; i < w && !hit; i++) begin
              if (rx_seq[i] == tx_seq[slot]) begin
                rx_seq[i] = SEQ_WIDTH'(next_rx);
                next_rx   = (next_rx + 1) % m;
                hit       = 1'b1;
              end
            end
            if (oc == OC_ACKED) begin
              tx_acked[slot] = 1'b1;
              st             = ST_ACKED;
            end else begin
              st = ST_ACKLOST;
            end
          end else begin
            st = (oc == OC_DAMAGED) ? ST_DAMAGED : ST_LOST;
          end
        end
      end
      owed_q.push_back('{RK_REPORT, seq, st, hit, !rend});
      if (rend) begin
        slide_window();
        owe_frames();
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_bits_q = SEQ_BITS_RST;
      act_bits   = SEQ_BITS_RST;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        tx_seq[i]   = '0;
        tx_acked[i] = 1'b0;
        rx_seq[i]   = '0;
      end
      next_tx   = 0;
      next_rx   = 0;
      n_checked = 0;
      n_bad     = 0;
      owed_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.result_kind, out_i.seq_number, out_i.status,
                out_i.receiver_accepted, out_i.last};
        n_checked++;
        if (owed_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("unexpected beat: kind %0d seq %0d status %0d acc %0d last %0d",
                     got.rk, got.seq, got.st, got.acc, got.last);
          end
        end else begin
          want = owed_q.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("beat %0d: expected kind %0d seq %0d status %0d acc %0d last %0d",
                       n_checked, want.rk, want.seq, want.st, want.acc, want.last);
              $display("beat %0d: got      kind %0d seq %0d status %0d acc %0d last %0d",
                       n_checked, got.rk, got.seq, got.st, got.acc, got.last);
            end
          end
        end
      end
      if (cfg_we_i) seq_bits_q = cfg_wdata_i;
      if (in_i.valid && in_i.ready) begin
        step_arq_window(in_i.kind, in_i.slot, in_i.outcome, in_i.round_end);
      end
    end
    pending_o    <= owed_q.size();
    checked_o    <= n_checked;
    mismatches_o <= n_bad;
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the selective-repeat ARQ window. Runs directed
// reports on the reset width, then random rounds over several sequence
// widths with random gaps and output stalls; the checker does the scoring.
// ----------------------------------------------------------------------------
module testbench;
  import sra_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned SETTLE      = 80;
  localparam int unsigned PHASE_ITEMS = 24;
  localparam logic [BITS_W-1:0] SEQ_BITS_PLAN [8] =
    '{3'd5, 3'd0, 3'd2, 3'd7, 3'd1, 3'd4, 3'd3, 3'd5};

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [BITS_W-1:0] cfg_wdata;
  int unsigned       owed_n;
  int unsigned       beats_n;
  int unsigned       bad_n;
  int unsigned       items_n;
  int unsigned       quiet_n;
  bit                calm;

  sra_in_if  in_if ();
  sra_out_if out_if ();

  selective_repeat_arq_window_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  sra_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_i         (in_if),
    .out_i        (out_if),
    .pending_o    (owed_n),
    .checked_o    (beats_n),
    .mismatches_o (bad_n)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic push_item(input logic kind, input logic [3:0] slot,
                           input logic [1:0] oc, input logic rend);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.slot      <= slot;
    in_if.outcome   <= oc;
    in_if.round_end <= rend;
    do @(posedge clk); while (!in_if.ready);
    items_n++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (owed_n != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_seq_bits(input logic [BITS_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly in-window reports, some restarts and out-of-window noise
  task automatic random_item(input int unsigned w);
    int unsigned pick;
    logic [1:0]  oc;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      push_item(KIND_START, 4'($urandom), 2'($urandom), 1'($urandom));
    end else if (pick < 14) begin
      push_item(KIND_REPORT, 4'($urandom), 2'($urandom), 1'($urandom));
    end else begin
      oc = ($urandom_range(0, 1) == 0) ? OC_ACKED : 2'($urandom);
      push_item(KIND_REPORT, 4'($urandom_range(0, w - 1)), oc, $urandom_range(0, 3) == 0);
    end
  endtask

  // output side: random stall per beat
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_n <= 0;
    else quiet_n <= quiet_n + 1;
    if (quiet_n >= IDLE_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results owed", quiet_n, owed_n);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned       w;
    int unsigned       p;
    logic [BITS_W-1:0] eff;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_if.valid     <= 1'b0;
    in_if.kind      <= KIND_REPORT;
    in_if.slot      <= '0;
    in_if.outcome   <= OC_ACKED;
    in_if.round_end <= 1'b0;
    calm            = 1'b0;
    items_n         = 0;
    quiet_n         = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width, window of four; reports before any start
    push_item(KIND_REPORT, 4'd0, OC_ACKED, 1'b0);
    push_item(KIND_REPORT, 4'd2, OC_LOST, 1'b1);
    // start with junk in the ignored fields
    push_item(KIND_START, 4'd15, OC_LOST, 1'b1);
    push_item(KIND_REPORT, 4'd0, OC_ACKED, 1'b0);
    push_item(KIND_REPORT, 4'd0, OC_ACKED, 1'b0);
    push_item(KIND_REPORT, 4'd1, OC_ACKLOST, 1'b0);
    // resend of a delivered frame, receiver no longer matches
    push_item(KIND_REPORT, 4'd1, OC_ACKLOST, 1'b0);
    push_item(KIND_REPORT, 4'd2, OC_DAMAGED, 1'b0);
    push_item(KIND_REPORT, 4'd3, OC_LOST, 1'b0);
    push_item(KIND_REPORT, 4'd15, OC_ACKED, 1'b0);
    push_item(KIND_REPORT, 4'd8, OC_ACKLOST, 1'b1);
    push_item(KIND_REPORT, 4'd0, OC_ACKED, 1'b0);
    push_item(KIND_REPORT, 4'd1, OC_ACKED, 1'b0);
    push_item(KIND_REPORT, 4'd2, OC_ACKED, 1'b0);
    // whole window acked, slide refills every slot
    push_item(KIND_REPORT, 4'd3, OC_ACKED, 1'b1);
    push_item(KIND_START, 4'd0, OC_ACKED, 1'b0);
    settle();

    for (p = 0; p < $size(SEQ_BITS_PLAN); p++) begin
      write_seq_bits(SEQ_BITS_PLAN[p]);
      if (SEQ_BITS_PLAN[p] == '0) eff = BITS_W'(1);
      else if (SEQ_BITS_PLAN[p] > SEQ_BITS_MAX) eff = SEQ_BITS_MAX;
      else eff = SEQ_BITS_PLAN[p];
      w    = 1 << (eff - 1);
      calm = ($urandom_range(0, 3) == 0);
      push_item(KIND_START, 4'd0, OC_ACKED, 1'b0);
      repeat (PHASE_ITEMS) random_item(w);
      settle();
    end

    $display("sent %0d items: directed reports on the reset width, then %0d random phases",
             items_n, $size(SEQ_BITS_PLAN));
    $display("checked %0d result beats across windows of 1 to 16 slots, %0d bad",
             beats_n, bad_n);
    if (bad_n == 0 && owed_n == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
